// ===== design/keyed_unordered_table_defines.svh =====
// assertion macros for the keyed unordered table checker
// no dependencies; included by files that hold concurrent assertions
`ifndef KEYED_UNORDERED_TABLE_DEFINES_SVH
`define KEYED_UNORDERED_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KUT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kut assertion failed");

// next-cycle implication, disabled during reset
`define KUT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kut assertion failed");

`endif

// ===== design/kut_pkg.sv =====
// shared types and codes for the keyed unordered table
// no dependencies
`timescale 1ns / 1ps

package kut_pkg;

    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_SUCCESS   = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EXISTS    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic [4:0] entry_count;
        logic       is_full;
        logic       is_empty;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_FOUND,
        SEL_COUNT
    } t_slot_sel;

    // controller to datapath
    typedef struct packed {
        logic       start;
        logic       scan;
        logic       res_wr;
        t_slot_sel  res_sel;
        logic [1:0] res_status;
        logic       append;
        logic       move_rd;
        logic       move_wr;
        logic       emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic full;
        logic out_free;
    } t_stat;

endpackage

// ===== design/kut_ctrl.sv =====
// controller state machine for the keyed unordered table
// depends on kut_pkg
`timescale 1ns / 1ps

module kut_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_op,
    input  kut_pkg::t_stat      i_stat,
    output logic                o_in_ready,
    output kut_pkg::t_cmd       o_cmd
);

    kut_pkg::t_state r_state;
    kut_pkg::t_state n_state;
    logic [1:0]      r_op;
    logic [1:0]      n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kut_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

    always_comb begin
        n_state          = r_state;
        n_op             = r_op;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.res_sel    = kut_pkg::SEL_ZERO;
        o_cmd.res_status = kut_pkg::ST_SUCCESS;
        unique case (r_state)
            kut_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_op        = i_in_op;
                    if (i_in_op == kut_pkg::OP_INSERT && i_stat.full) begin
                        o_cmd.res_wr     = 1'b1;
                        o_cmd.res_status = kut_pkg::ST_FULL;
                        n_state          = kut_pkg::S_DONE;
                    end else begin
                        n_state = kut_pkg::S_SCAN;
                    end
                end
            end
            kut_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                // most scan cycles see neither a hit nor a miss
                if (i_stat.hit) begin
                    o_cmd.res_wr = 1'b1;
                    if (r_op == kut_pkg::OP_INSERT) begin
                        o_cmd.res_status = kut_pkg::ST_EXISTS;
                        n_state          = kut_pkg::S_DONE;
                    end else if (r_op == kut_pkg::OP_REMOVE) begin
                        o_cmd.res_sel = kut_pkg::SEL_FOUND;
                        n_state       = kut_pkg::S_MOVE_RD;
                    end else begin
                        o_cmd.res_sel = kut_pkg::SEL_FOUND;
                        n_state       = kut_pkg::S_DONE;
                    end
                end else if (i_stat.miss) begin
                    o_cmd.res_wr = 1'b1;
                    if (r_op == kut_pkg::OP_INSERT) begin
                        o_cmd.res_sel = kut_pkg::SEL_COUNT;
                        o_cmd.append  = 1'b1;
                    end else begin
                        o_cmd.res_status = kut_pkg::ST_NOT_FOUND;
                    end
                    n_state = kut_pkg::S_DONE;
                end
            end
            kut_pkg::S_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = kut_pkg::S_MOVE_WR;
            end
            kut_pkg::S_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                n_state       = kut_pkg::S_DONE;
            end
            kut_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = kut_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kut_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/kut_datapath.sv =====
// key store, scan pipeline, count and result register for the table
// depends on kut_pkg
`timescale 1ns / 1ps

module kut_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kut_pkg::t_in_item   i_in_data,
    input  kut_pkg::t_cmd       i_cmd,
    input  logic                i_out_ready,
    output kut_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    output kut_pkg::t_out_item  o_out_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [31:0]        r_mem [CAPACITY];
    logic [31:0]        r_rdata;
    logic [31:0]        r_key;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [IDX_W-1:0]   r_slot;
    logic [1:0]         r_status;
    logic               r_out_vld;
    kut_pkg::t_out_item r_out;

    logic               rd_issue;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [31:0]        wr_data;
    logic [CNT_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   n_slot;
    logic [IDX_W+3:0]   slot_ext;
    logic [CNT_W+4:0]   cnt_ext;

    assign cnt_m1   = r_count - CNT_W'(1);
    assign rd_issue = i_cmd.scan && (r_rd_idx < r_count);
    assign rd_en    = rd_issue || i_cmd.move_rd;
    assign rd_addr  = i_cmd.move_rd ? cnt_m1[IDX_W-1:0] : r_rd_idx[IDX_W-1:0];
    assign wr_en    = i_cmd.append || i_cmd.move_wr;
    assign wr_addr  = i_cmd.append ? r_count[IDX_W-1:0] : r_slot;
    assign wr_data  = i_cmd.append ? r_key : r_rdata;

    assign o_stat.hit      = r_cmp_vld && (r_rdata == r_key);
    assign o_stat.miss     = !r_cmp_vld && (r_rd_idx >= r_count);
    assign o_stat.full     = (r_count >= CAP_CNT);
    assign o_stat.out_free = !r_out_vld || i_out_ready;

    always_comb begin
        unique case (i_cmd.res_sel)
            kut_pkg::SEL_FOUND: n_slot = r_cmp_idx;
            kut_pkg::SEL_COUNT: n_slot = r_count[IDX_W-1:0];
            default:            n_slot = '0;
        endcase
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= rd_issue;
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.move_wr) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign slot_ext = {4'b0, r_slot};
    assign cnt_ext  = {5'b0, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key    <= i_in_data.key;
            r_rd_idx <= '0;
        end else if (rd_issue) begin
            r_rd_idx <= r_rd_idx + CNT_W'(1);
        end
        if (rd_issue) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (i_cmd.res_wr) begin
            r_status <= i_cmd.res_status;
            r_slot   <= n_slot;
        end
        if (i_cmd.emit) begin
            r_out.status      <= r_status;
            r_out.slot        <= slot_ext[3:0];
            r_out.entry_count <= cnt_ext[4:0];
            r_out.is_full     <= (r_count == CAP_CNT);
            r_out.is_empty    <= (r_count == '0);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== design/keyed_unordered_table.sv =====
// top level of the keyed unordered table: controller plus datapath
// depends on kut_pkg, kut_ctrl, kut_datapath
`timescale 1ns / 1ps

// usage
// - input channel: i_in_valid / o_in_ready carry one beat per operation
//   (op: search, insert, remove; op code 3 acts as search) with a signed key
// - output channel: o_out_valid / i_out_ready carry one result beat per
//   operation: status, slot, entry count, full and empty flags
// - one operation at a time; ready is high only while the controller idles
// - search walks stored slots 0..count-1 through the single read port of the
//   key store, one slot per cycle, each compared after its registered read
// - a remove that hits also reads and writes back the last entry; an insert
//   into a full table skips the scan; the scan stops early at the first match
// - the result beat turns valid in the same cycle as the next beat can be taken
// - the result goes into an output register, so a stalled receiver only
//   holds the block once the next result is ready to leave
// - synchronous reset empties the table (count to zero) and drops any
//   pending result; key store contents are left as they are
// - the key store is a CAPACITY x 32 memory, one write and one read port

module keyed_unordered_table #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kut_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kut_pkg::t_out_item  o_out_data
);

    // command and status between controller and datapath
    kut_pkg::t_cmd  cmd;
    kut_pkg::t_stat stat;

    kut_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.op),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    kut_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/kut_checker.sv =====
// port-level checker for the keyed unordered table, bound to the top level
// depends on kut_pkg and keyed_unordered_table_defines.svh
`timescale 1ns / 1ps
`include "keyed_unordered_table_defines.svh"

module kut_checker #(
    parameter int CAPACITY = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input kut_pkg::t_in_item  i_in_data,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input kut_pkg::t_out_item i_out_data
);

    localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

    // a stalled result beat holds
    `KUT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // failed operations report slot zero
    `KUT_ASSERT_NOW(a_fail_slot, i_clk, i_rst_n, i_out_valid && (i_out_data.status != kut_pkg::ST_SUCCESS), i_out_data.slot == 4'd0)

    // a full rejection only while the table is full
    `KUT_ASSERT_NOW(a_full_flag, i_clk, i_rst_n, i_out_valid && (i_out_data.status == kut_pkg::ST_FULL), i_out_data.is_full && (i_out_data.entry_count == CAP_LOW))

    // a duplicate means something is stored
    `KUT_ASSERT_NOW(a_exists_nonempty, i_clk, i_rst_n, i_out_valid && (i_out_data.status == kut_pkg::ST_EXISTS), !i_out_data.is_empty)

endmodule

bind keyed_unordered_table kut_checker #(
    .CAPACITY (CAPACITY)
) u_kut_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

// ===== verif/keyed_unordered_table_tb.sv =====
// self-checking testbench for keyed_unordered_table: directed and random operation beats
// depends on kut_pkg and keyed_unordered_table; carries its own model of the key table
`timescale 1ns / 1ps

module keyed_unordered_table_tb;

    localparam int CAPACITY       = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;   // spare op code, behaves as a search
    localparam int NO_SLOT        = -1;
    localparam int RESET_CYCLES   = 11;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 10;
    localparam int POOL_SIZE      = 24;

    // dut ports; the inputs are at known values from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    kut_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    kut_pkg::t_out_item o_out_data;

    // model state: stored keys and how many are in use
    logic signed [31:0] key_store [CAPACITY];
    int unsigned        key_count = 0;

    // small key pool so duplicates and hits are common
    logic signed [31:0] key_pool [POOL_SIZE];

    // results the model has worked out, oldest first
    kut_pkg::t_out_item predicted_outcomes [$];

    bit          idle_on      = 1'b1;  // random gaps on both channels
    int          rx_hold_req  = 0;     // bumped to ask the receiver for a long hold
    int          rx_hold_done = 0;
    int          fail_count   = 0;
    int unsigned cycle_count  = 0;

    keyed_unordered_table #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // model of the table
    // ------------------------------------------------------------------

    // lowest slot holding the key, only slots in use are looked at
    function automatic int find_key(logic signed [31:0] key);
        for (int i = 0; i < key_count; i++) begin
            if (key_store[i] == key) begin
                return i;
            end
        end
        return NO_SLOT;
    endfunction

    // applies one operation to the model and returns the result beat it causes
    function automatic kut_pkg::t_out_item apply_table_op(kut_pkg::t_in_item beat);
        kut_pkg::t_out_item res;
        int                 pos;
        res        = '0;
        res.status = kut_pkg::ST_SUCCESS;
        pos        = find_key(beat.key);
        case (beat.op)
            kut_pkg::OP_INSERT: begin
                // full wins over duplicate
                if (key_count >= CAPACITY) begin
                    res.status = kut_pkg::ST_FULL;
                end else if (pos != NO_SLOT) begin
                    res.status = kut_pkg::ST_EXISTS;
                end else begin
                    res.slot             = 4'(key_count);
                    key_store[key_count] = beat.key;
                    key_count++;
                end
            end
            kut_pkg::OP_REMOVE: begin
                if (pos == NO_SLOT) begin
                    res.status = kut_pkg::ST_NOT_FOUND;
                end else begin
                    // last entry fills the hole; for the last slot it copies onto itself
                    key_store[pos] = key_store[key_count - 1];
                    key_count--;
                    res.slot = 4'(pos);
                end
            end
            default: begin
                // search and the spare op code
                if (pos == NO_SLOT) begin
                    res.status = kut_pkg::ST_NOT_FOUND;
                end else begin
                    res.slot = 4'(pos);
                end
            end
        endcase
        res.entry_count = 5'(key_count);
        res.is_full     = (key_count == CAPACITY);
        res.is_empty    = (key_count == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // idle pattern helpers
    // ------------------------------------------------------------------

    // mostly short, now and then long
    function automatic int stall_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // sender gap after a beat, zero for back to back
    function automatic int pick_gap();
        if (!idle_on || $urandom_range(0, 99) < 50) begin
            return 0;
        end
        return stall_length();
    endfunction

    // key that is stored now with the given odds, else from the pool or fully random
    function automatic logic signed [31:0] pick_key(int present_pct);
        if (key_count > 0 && $urandom_range(0, 99) < present_pct) begin
            return key_store[$urandom_range(0, key_count - 1)];
        end
        if ($urandom_range(0, 99) < 70) begin
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offers one beat and holds it until accepted; valid stays high when the
    // next beat follows with no gap, so it is never lowered and raised in one step
    task automatic send_op(logic [1:0] op, logic signed [31:0] key);
        kut_pkg::t_in_item beat;
        int                gap;
        beat.op  = op;
        beat.key = key;
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predicted_outcomes.push_back(apply_table_op(beat));
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one random operation; insert keys are mostly new, remove keys mostly stored
    task automatic send_random(int insert_pct, int remove_pct);
        int                 r;
        logic [1:0]         op;
        logic signed [31:0] key;
        r = $urandom_range(0, 99);
        if (r < insert_pct) begin
            op  = kut_pkg::OP_INSERT;
            key = pick_key(15);
        end else if (r < insert_pct + remove_pct) begin
            op  = kut_pkg::OP_REMOVE;
            key = pick_key(65);
        end else if (r < insert_pct + remove_pct + 6) begin
            op  = OP_UNUSED;
            key = pick_key(50);
        end else begin
            op  = kut_pkg::OP_SEARCH;
            key = pick_key(50);
        end
        send_op(op, key);
    endtask

    // sender stops until every predicted result has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (predicted_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    // receiver: random stalls, plus a long hold when one is asked for
    initial begin : rx_side
        int stall;
        forever begin
            @(posedge i_clk);
            stall = 0;
            if (rx_hold_req != rx_hold_done) begin
                rx_hold_done = rx_hold_req;
                stall        = RX_HOLD_CYCLES;
            end else if (idle_on && $urandom_range(0, 99) < 15) begin
                stall = stall_length();
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // every accepted result beat against the oldest prediction
    always @(posedge i_clk) begin : check_results
        kut_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_outcomes.size() == 0) begin
                $error("result beat with no operation outstanding");
                fail_count++;
            end else begin
                want = predicted_outcomes.pop_front();
                compare_field("status", want.status, o_out_data.status);
                compare_field("slot", want.slot, o_out_data.slot);
                compare_field("entry_count", want.entry_count, o_out_data.entry_count);
                compare_field("is_full", want.is_full, o_out_data.is_full);
                compare_field("is_empty", want.is_empty, o_out_data.is_empty);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("keyed_unordered_table regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes, the spare op code, and the corner cases of insert and remove
    task automatic test_directed();
        // remove from an empty table
        send_op(kut_pkg::OP_REMOVE, 32'sd0);
        // extreme keys go into slots 0..2
        send_op(kut_pkg::OP_INSERT, 32'sh8000_0000);
        send_op(kut_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        send_op(kut_pkg::OP_INSERT, -32'sd1);
        // duplicate insert
        send_op(kut_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        // spare op code searches
        send_op(OP_UNUSED, -32'sd1);
        // remove of an absent key
        send_op(kut_pkg::OP_REMOVE, 32'sd12345);
        // remove slot 0, last entry moves down
        send_op(kut_pkg::OP_REMOVE, 32'sh8000_0000);
        // remove of the last slot copies onto itself
        send_op(kut_pkg::OP_REMOVE, 32'sh7FFF_FFFF);
        // fill up: zero plus fourteen distinct patterns
        send_op(kut_pkg::OP_INSERT, 32'sd0);
        for (int i = 1; i <= 14; i++) begin
            send_op(kut_pkg::OP_INSERT, 32'(i) * 32'sh1111_1111);
        end
        // insert into a full table, new key and stored key
        send_op(kut_pkg::OP_INSERT, 32'sh7FFF_FFFF);
        send_op(kut_pkg::OP_INSERT, -32'sd1);
        wait_results_drained();
    endtask

    // swings between full and empty several times
    task automatic test_fill_and_empty();
        for (int round = 0; round < 4; round++) begin
            repeat (30) send_random(75, 10);
            repeat (30) send_random(10, 75);
        end
        wait_results_drained();
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_output_hold();
        rx_hold_req++;
        repeat (30) send_random(45, 35);
        wait_results_drained();
    endtask

    // a stretch with no idling on either side
    task automatic test_no_idle();
        idle_on = 1'b0;
        repeat (80) send_random(40, 30);
        wait_results_drained();
        idle_on = 1'b1;
    endtask

    // bulk of the random beats, balanced mix
    task automatic test_random_mix();
        repeat (280) send_random(35, 30);
        wait_results_drained();
    endtask

    initial begin
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        key_pool[4] = 32'sd1;
        for (int i = 5; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
        end

        // synchronous reset, once
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_and_empty();
        test_output_hold();
        test_no_idle();
        test_random_mix();

        if (fail_count == 0) begin
            $display("keyed_unordered_table regression: pass");
        end else begin
            $display("keyed_unordered_table regression: fail");
        end
        $finish;
    end

endmodule
